// File: sv/ssp_pkg.sv
package ssp_pkg;

    localparam int MAX_FRAMES_DEF = 65536;
    localparam int MAX_SLICES_DEF = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;

    localparam int DIV_N_W = 40;
    localparam int DIV_D_W = 21;

    localparam int POS_W = 41;

    localparam logic [16:0] UNITY    = 17'd65536;
    localparam logic [22:0] FREQ_MAX = 23'd6144000;
    localparam logic [27:0] PITCH_MAX = 28'd268435455;
    localparam logic [POS_W:0] HEAD_MAX = 42'd1099511627775;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEVEL      = 3'd0,
        CFG_LOOP       = 3'd1,
        CFG_ROOT       = 3'd2,
        CFG_SLICES     = 3'd3,
        CFG_START      = 3'd4,
        CFG_LENGTH     = 3'd5,
        CFG_FRAMES     = 3'd6,
        CFG_RATE       = 3'd7
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_SF,
        ST_TRIG_MUL,
        ST_TRIG_SET,
        ST_PLAY,
        ST_RD0,
        ST_RD1,
        ST_MIX0,
        ST_MIX1,
        ST_MIX2,
        ST_MIX3,
        ST_DIV_PITCH,
        ST_STEP,
        ST_ADV,
        ST_OUT
    } state_t;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_TICK = 1'b1
    } command_t;

endpackage

// File: sv/ssp_divider.sv
module ssp_divider (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [ssp_pkg::DIV_N_W-1:0]  dividend,
    input  logic [ssp_pkg::DIV_D_W-1:0]  divisor,
    output logic                         busy,
    output logic [ssp_pkg::DIV_N_W-1:0]  quotient
);
    import ssp_pkg::*;

    localparam int CNT_W = $clog2(DIV_N_W + 1);

    logic [DIV_D_W:0]   rem_reg, rem_next;
    logic [DIV_N_W-1:0] quo_reg, quo_next;
    logic [DIV_D_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic [DIV_D_W:0]   shifted;
    logic               fits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    always_comb
    begin
        shifted   = {rem_reg[DIV_D_W-1:0], quo_reg[DIV_N_W-1]};
        fits      = shifted >= {1'b0, den_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
            cnt_next  = CNT_W'(DIV_N_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? shifted - {1'b0, den_reg} : shifted;
            quo_next = {quo_reg[DIV_N_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// File: sv/sliced_sample_player.sv
// Load words: memory written at acceptance.
// Tick words: while a voice plays, each waits on the 40-step shared divider for the pitch quotient;
// a tick on a rising gate first also waits on it for the slice-length division.
// One word at a time; the next word is taken while a result waits in the output register.
// Reset (rst_n, asynchronous) clears control state and loads register defaults;
// sample memory is undefined until written.
module sliced_sample_player #(
    parameter int MAX_FRAMES = ssp_pkg::MAX_FRAMES_DEF,
    parameter int MAX_SLICES = ssp_pkg::MAX_SLICES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ssp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ssp_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            command,
    input  logic [15:0]                     load_address,
    input  logic signed [15:0]              load_value,
    input  logic                            gate,
    input  logic                            slice_connected,
    input  logic [16:0]                     slice_position,
    input  logic                            pitch_connected,
    input  logic [22:0]                     frequency,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [15:0]              sample_out,
    output logic                            playing
);
    import ssp_pkg::*;

    localparam int MEM_AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

    logic [16:0] level_reg;
    logic        loop_reg;
    logic [20:0] root_reg;
    logic [4:0]  slices_cfg_reg;
    logic [16:0] start_reg;
    logic [16:0] length_reg;
    logic [16:0] frames_cfg_reg;
    logic [18:0] rate_reg;

    state_t state_reg, state_next;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] begin_reg, begin_next;
    logic [POS_W-1:0] end_reg, end_next;
    logic             active_reg, active_next;
    logic             gate_prev_reg, gate_prev_next;
    logic             out_valid_reg, out_valid_next;
    logic signed [15:0] out_sample_reg, out_sample_next;
    logic             out_play_reg, out_play_next;
    logic signed [15:0] res_sample_reg, res_sample_next;
    logic             res_play_reg, res_play_next;

    logic        pc_reg;
    logic [22:0] freq_reg;
    logic [5:0]  slice_reg;
    logic [32:0] sf_reg;
    logic [37:0] base_reg;
    logic [49:0] pstart_reg;
    logic [49:0] pstop_reg;
    logic signed [15:0] s0_reg;
    logic signed [15:0] s1_reg;
    logic signed [33:0] p0_reg;
    logic signed [33:0] p1_reg;
    logic signed [34:0] mix_reg;
    logic signed [52:0] scaled_reg;
    logic [30:0] step_reg;

    logic signed [15:0] mem [MAX_FRAMES];
    logic [MEM_AW-1:0]  rd_addr;
    logic signed [15:0] mem_q_reg;
    logic               rd_ok, rd_ok_reg;

    logic               div_start;
    logic [DIV_N_W-1:0] div_dividend;
    logic [DIV_D_W-1:0] div_divisor;
    logic               div_busy;
    logic [DIV_N_W-1:0] div_q;

    logic [16:0] frames;
    logic [4:0]  slices;
    logic [16:0] start_c;
    logic [16:0] stop_c;
    logic [16:0] lvl_c;
    logic [16:0] spos_c;
    logic [22:0] freq_c;
    logic [21:0] slice_prod;
    logic [5:0]  slice_raw;
    logic [5:0]  slice_sel;
    logic [POS_W-1:0] last_pos;
    logic [24:0] idx0;
    logic [25:0] idx1;
    logic [16:0] frac;
    logic [27:0] pitch_sel;
    logic [POS_W:0]   adv_sum;
    logic [POS_W:0]   adv_cap;
    logic [POS_W-1:0] trig_begin;
    logic [POS_W-1:0] trig_end;
    logic signed [52:0] rounded;
    logic signed [20:0] res_wide;
    logic in_acc;
    logic load_acc;
    logic trig;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign load_acc  = in_acc && (command == CMD_LOAD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg      <= 17'd52429;
            loop_reg       <= 1'b0;
            root_reg       <= 21'd66977;
            slices_cfg_reg <= 5'd1;
            start_reg      <= 17'd0;
            length_reg     <= 17'd65536;
            frames_cfg_reg <= 17'd0;
            rate_reg       <= 19'd65536;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LEVEL:  level_reg      <= cfg_data[16:0];
                CFG_LOOP:   loop_reg       <= cfg_data[0];
                CFG_ROOT:   root_reg       <= cfg_data[20:0];
                CFG_SLICES: slices_cfg_reg <= cfg_data[4:0];
                CFG_START:  start_reg      <= cfg_data[16:0];
                CFG_LENGTH: length_reg     <= cfg_data[16:0];
                CFG_FRAMES: frames_cfg_reg <= cfg_data[16:0];
                CFG_RATE:   rate_reg       <= cfg_data[18:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_acc && (32'(load_address) < MAX_FRAMES))
        begin
            mem[MEM_AW'(load_address)] <= load_value;
        end
        mem_q_reg <= mem[rd_addr];
        rd_ok_reg <= rd_ok;
    end

    ssp_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_q)
    );

    always_comb
    begin
        frames  = (32'(frames_cfg_reg) > MAX_FRAMES) ? 17'(MAX_FRAMES) : frames_cfg_reg;
        if (slices_cfg_reg == 5'd0)
        begin
            slices = 5'd1;
        end
        else
        begin
            slices = (32'(slices_cfg_reg) > MAX_SLICES) ? 5'(MAX_SLICES) : slices_cfg_reg;
        end
        start_c = (start_reg > UNITY) ? UNITY : start_reg;
        stop_c  = (18'(start_c) + 18'((length_reg > UNITY) ? UNITY : length_reg)
                   > 18'(UNITY)) ? UNITY
                   : 17'(start_c + ((length_reg > UNITY) ? UNITY : length_reg));
        lvl_c   = (level_reg > UNITY) ? UNITY : level_reg;
        spos_c  = (slice_position > UNITY) ? UNITY : slice_position;
        freq_c  = (freq_reg > FREQ_MAX) ? FREQ_MAX : freq_reg;
        slice_prod = spos_c * slices;
        slice_raw  = slice_prod[21:16];
        if (!slice_connected)
        begin
            slice_sel = 6'd0;
        end
        else
        begin
            slice_sel = (slice_raw >= 6'(slices)) ? 6'(slices) - 6'd1 : slice_raw;
        end
        last_pos = POS_W'({(frames - 17'd1), 16'd0});
        idx0 = pos_reg[POS_W-1:16];
        idx1 = 26'(idx0) + 26'd1;
        frac = {1'b0, pos_reg[15:0]};
        if (!pc_reg)
        begin
            pitch_sel = 28'(UNITY);
        end
        else if (root_reg == 21'd0)
        begin
            pitch_sel = PITCH_MAX;
        end
        else
        begin
            pitch_sel = (div_q > DIV_N_W'(PITCH_MAX)) ? PITCH_MAX : div_q[27:0];
        end
        adv_sum = {1'b0, pos_reg} + (POS_W + 1)'(step_reg);
        adv_cap = (adv_sum > HEAD_MAX) ? HEAD_MAX : adv_sum;
        trig_begin = POS_W'(base_reg) + POS_W'(pstart_reg[49:16]);
        trig_end   = POS_W'(base_reg) + POS_W'(pstop_reg[49:16]);
        rounded  = scaled_reg + 53'sd2147483648;
        res_wide = 21'(rounded >>> 32);
        trig = (frames >= 17'd2) && gate && !gate_prev_reg;
    end

    always_comb
    begin
        rd_addr = '0;
        rd_ok   = 1'b0;
        case (state_reg)
            ST_PLAY:
            begin
                rd_addr = MEM_AW'(idx0);
                rd_ok   = 32'(idx0) < MAX_FRAMES;
            end
            ST_RD0:
            begin
                rd_addr = MEM_AW'(idx1);
                rd_ok   = 32'(idx1) < MAX_FRAMES;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = {freq_c, 16'd0};
        div_divisor  = root_reg;
        if (state_reg == ST_IDLE)
        begin
            div_dividend = DIV_N_W'({frames, 16'd0});
            div_divisor  = DIV_D_W'(slices);
            div_start    = in_acc && (command == CMD_TICK) && trig;
        end
        else if (state_reg == ST_PLAY)
        begin
            div_start = active_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            begin_reg     <= '0;
            end_reg       <= '0;
            active_reg    <= 1'b0;
            gate_prev_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            res_play_reg  <= 1'b0;
            out_play_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            begin_reg     <= begin_next;
            end_reg       <= end_next;
            active_reg    <= active_next;
            gate_prev_reg <= gate_prev_next;
            out_valid_reg <= out_valid_next;
            res_play_reg  <= res_play_next;
            out_play_reg  <= out_play_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_sample_reg <= res_sample_next;
        out_sample_reg <= out_sample_next;
        if (in_acc)
        begin
            pc_reg    <= pitch_connected;
            freq_reg  <= frequency;
            slice_reg <= slice_sel;
        end
        if (state_reg == ST_DIV_SF && !div_busy)
        begin
            sf_reg <= div_q[32:0];
        end
        if (state_reg == ST_TRIG_MUL)
        begin
            base_reg   <= 38'(slice_reg * sf_reg);
            pstart_reg <= 50'(start_c * sf_reg);
            pstop_reg  <= 50'(stop_c * sf_reg);
        end
        if (state_reg == ST_RD0)
        begin
            s0_reg <= rd_ok_reg ? mem_q_reg : 16'sd0;
        end
        if (state_reg == ST_RD1)
        begin
            s1_reg <= rd_ok_reg ? mem_q_reg : 16'sd0;
        end
        if (state_reg == ST_MIX0)
        begin
            p0_reg <= 34'(s0_reg * $signed({1'b0, UNITY - frac}));
            p1_reg <= 34'(s1_reg * $signed({1'b0, frac}));
        end
        if (state_reg == ST_MIX1)
        begin
            mix_reg <= 35'(p0_reg) + 35'(p1_reg);
        end
        if (state_reg == ST_MIX2)
        begin
            scaled_reg <= 53'(mix_reg * $signed({1'b0, lvl_c}));
        end
        if (state_reg == ST_STEP)
        begin
            step_reg <= 31'((47'(rate_reg) * 47'(pitch_sel)) >> 16);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        begin_next      = begin_reg;
        end_next        = end_reg;
        active_next     = active_reg;
        gate_prev_next  = gate_prev_reg;
        out_valid_next  = out_valid_reg;
        out_sample_next = out_sample_reg;
        out_play_next   = out_play_reg;
        res_sample_next = res_sample_reg;
        res_play_next   = res_play_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (command == CMD_TICK))
                begin
                    res_sample_next = 16'sd0;
                    res_play_next   = 1'b0;
                    if (frames < 17'd2)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        gate_prev_next = gate;
                        state_next     = trig ? ST_DIV_SF : ST_PLAY;
                    end
                end
            end
            ST_DIV_SF:
            begin
                if (!div_busy)
                begin
                    state_next = ST_TRIG_MUL;
                end
            end
            ST_TRIG_MUL:
            begin
                state_next = ST_TRIG_SET;
            end
            ST_TRIG_SET:
            begin
                begin_next  = trig_begin;
                end_next    = (trig_end > last_pos) ? last_pos : trig_end;
                pos_next    = trig_begin;
                active_next = ((trig_end > last_pos) ? last_pos : trig_end) > trig_begin;
                state_next  = ST_PLAY;
            end
            ST_PLAY:
            begin
                state_next = active_reg ? ST_RD0 : ST_OUT;
            end
            ST_RD0:
            begin
                state_next = ST_RD1;
            end
            ST_RD1:
            begin
                state_next = ST_MIX0;
            end
            ST_MIX0:
            begin
                state_next = ST_MIX1;
            end
            ST_MIX1:
            begin
                state_next = ST_MIX2;
            end
            ST_MIX2:
            begin
                state_next = ST_MIX3;
            end
            ST_MIX3:
            begin
                if (res_wide > 21'sd32767)
                begin
                    res_sample_next = 16'sd32767;
                end
                else if (res_wide < -21'sd32768)
                begin
                    res_sample_next = -16'sd32768;
                end
                else
                begin
                    res_sample_next = 16'(res_wide);
                end
                res_play_next = 1'b1;
                state_next    = ST_DIV_PITCH;
            end
            ST_DIV_PITCH:
            begin
                if (!div_busy)
                begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                state_next = ST_ADV;
            end
            ST_ADV:
            begin
                pos_next = adv_cap[POS_W-1:0];
                if (adv_cap >= {1'b0, end_reg})
                begin
                    if (loop_reg)
                    begin
                        pos_next = POS_W'({1'b0, begin_reg} + (adv_cap - {1'b0, end_reg}));
                    end
                    else
                    begin
                        active_next = 1'b0;
                    end
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_sample_next = res_sample_reg;
                    out_play_next   = res_play_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = out_sample_reg;
    assign playing    = out_play_reg;

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import ssp_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE = 150;

    class playback_model;
        logic signed [15:0] mem [65536];
        logic [63:0] head, win_begin, win_end;
        bit running, gate_was;
        logic [63:0] level, loop_on, root, slices_reg, start_frac, length_frac, frames_reg,
            rate;
        logic [15:0] expected_samples [$];
        bit expected_playing [$];
        int errors;

        function void reset();
            head = 0;
            win_begin = 0;
            win_end = 0;
            running = 0;
            gate_was = 0;
            level = 52429;
            loop_on = 0;
            root = 66977;
            slices_reg = 1;
            start_frac = 0;
            length_frac = 65536;
            frames_reg = 0;
            rate = 65536;
            errors = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [20:0] d);
            case (idx)
                CFG_LEVEL:  level = d[16:0];
                CFG_LOOP:   loop_on = d[0];
                CFG_ROOT:   root = d[20:0];
                CFG_SLICES: slices_reg = d[4:0];
                CFG_START:  start_frac = d[16:0];
                CFG_LENGTH: length_frac = d[16:0];
                CFG_FRAMES: frames_reg = d[16:0];
                CFG_RATE:   rate = d[18:0];
                default: ;
            endcase
        endfunction

        function logic [63:0] cap(logic [63:0] v, logic [63:0] hi);
            return v > hi ? hi : v;
        endfunction

        function longint frame_at(logic [63:0] a);
            if (a >= 65536)
                return 0;
            return longint'(mem[a[15:0]]);
        endfunction

        function void retrigger(logic [63:0] frames, bit sconn, logic [16:0] spos);
            logic [63:0] nsl, sf, sel, st, sp, base;
            nsl = slices_reg == 0 ? 1 : cap(slices_reg, 16);
            sf = (frames << 16) / nsl;
            sel = 0;
            st = cap(start_frac, 65536);
            sp = cap(st + cap(length_frac, 65536), 65536);
            if (sconn)
            begin
                sel = (cap(spos, 65536) * nsl) >> 16;
                if (sel >= nsl)
                    sel = nsl - 1;
            end
            base = sel * sf;
            win_begin = base + ((st * sf) >> 16);
            win_end = base + ((sp * sf) >> 16);
            if (win_end > ((frames - 1) << 16))
                win_end = (frames - 1) << 16;
            head = win_begin;
            running = win_end > win_begin;
        endfunction

        function void note(command_t cmd, logic [15:0] addr, logic [15:0] val, bit g,
                           bit sconn, logic [16:0] spos, bit pconn, logic [22:0] freq);
            logic [63:0] frames, idx, frac, pitch, stp, f;
            longint interp, scaled, y, res;
            if (cmd == CMD_LOAD)
            begin
                mem[addr] = val;
                return;
            end
            frames = cap(frames_reg, 65536);
            if (frames < 2)
            begin
                expected_samples.push_back(16'd0);
                expected_playing.push_back(1'b0);
                return;
            end
            if (g && !gate_was)
                retrigger(frames, sconn, spos);
            gate_was = g;
            if (!running)
            begin
                expected_samples.push_back(16'd0);
                expected_playing.push_back(1'b0);
                return;
            end
            idx = head >> 16;
            frac = head & 64'hFFFF;
            interp = frame_at(idx) * longint'(65536 - frac) + frame_at(idx + 1) * longint'(frac);
            scaled = interp * longint'(cap(level, 65536));
            y = scaled + (64'sd1 <<< 31) + (64'sd1 <<< 48);
            res = (y >>> 32) - 65536;
            if (res > 32767)
                res = 32767;
            if (res < -32768)
                res = -32768;
            expected_samples.push_back(res[15:0]);
            expected_playing.push_back(1'b1);
            if (pconn)
            begin
                f = cap(freq, 6144000);
                pitch = root == 0 ? 64'd268435455 : cap((f << 16) / root, 268435455);
            end
            else
                pitch = 65536;
            stp = (rate * pitch) >> 16;
            head = cap(head + stp, 64'd1099511627775);
            if (head >= win_end)
            begin
                if (loop_on)
                    head = win_begin + (head - win_end);
                else
                    running = 0;
            end
        endfunction

        function void check(logic [15:0] smp, bit pl);
            if (expected_samples.size() == 0)
            begin
                $display("%0t: unexpected word sample_out %0d playing %0d", $time,
                         $signed(smp), pl);
                errors++;
                return;
            end
            if (smp !== expected_samples[0])
            begin
                $display("%0t: sample_out expected %0d actual %0d", $time,
                         $signed(expected_samples[0]), $signed(smp));
                errors++;
            end
            if (pl !== expected_playing[0])
            begin
                $display("%0t: playing expected %0d actual %0d", $time,
                         expected_playing[0], pl);
                errors++;
            end
            void'(expected_samples.pop_front());
            void'(expected_playing.pop_front());
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic command = 1'b0;
    logic [15:0] load_address = '0;
    logic signed [15:0] load_value = '0;
    logic gate = 1'b0;
    logic slice_connected = 1'b0;
    logic [16:0] slice_position = '0;
    logic pitch_connected = 1'b0;
    logic [22:0] frequency = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [15:0] sample_out;
    logic playing;

    logic in_took = 1'b0;
    logic cfg_took = 1'b0;
    bit no_idle = 0;
    int stall_left = 0;
    int cycles = 0;
    playback_model model = new();

    sliced_sample_player u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .command(command),
        .load_address(load_address), .load_value(load_value), .gate(gate),
        .slice_connected(slice_connected), .slice_position(slice_position),
        .pitch_connected(pitch_connected), .frequency(frequency),
        .out_valid(out_valid), .out_ready(out_ready), .sample_out(sample_out),
        .playing(playing)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        in_took <= in_valid && in_ready;
        cfg_took <= cfg_valid && cfg_ready;
        if (rst_n && cfg_valid && cfg_ready)
            model.write_reg(cfg_index_t'(cfg_index), cfg_data);
        if (rst_n && in_valid && in_ready)
            model.note(command_t'(command), load_address, load_value, gate, slice_connected,
                       slice_position, pitch_connected, frequency);
        if (rst_n && out_valid && out_ready)
            model.check(sample_out, playing);
    end

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else if (!no_idle && $urandom_range(0, 9) == 0)
        begin
            stall_left <= pick_gap();
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    task automatic send_word(command_t cmd, logic [15:0] addr, logic [15:0] val, bit g,
                             bit sconn, logic [16:0] spos, bit pconn, logic [22:0] freq);
        int gap;
        in_valid = 1'b1;
        command = cmd;
        load_address = addr;
        load_value = val;
        gate = g;
        slice_connected = sconn;
        slice_position = spos;
        pitch_connected = pconn;
        frequency = freq;
        do @(negedge clk); while (!in_took);
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic load_word(logic [15:0] addr, logic [15:0] val);
        send_word(CMD_LOAD, addr, val, $urandom_range(0, 1), $urandom_range(0, 1),
                  $urandom_range(0, 131071), $urandom_range(0, 1), $urandom_range(0, 8388607));
    endtask

    task automatic tick(bit g, bit sconn, logic [16:0] spos, bit pconn, logic [22:0] freq);
        send_word(CMD_TICK, $urandom, $urandom, g, sconn, spos, pconn, freq);
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (model.pending() > 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [20:0] d);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = d;
        do @(negedge clk); while (!cfg_took);
        cfg_valid = 1'b0;
    endtask

    task automatic random_setting();
        int r;
        r = $urandom_range(0, 9);
        write_reg(CFG_LEVEL, r < 2 ? 65536 : (r < 3 ? $urandom_range(0, 131071)
                                              : $urandom_range(0, 65536)));
        write_reg(CFG_LOOP, $urandom_range(0, 1));
        r = $urandom_range(0, 9);
        write_reg(CFG_ROOT, r < 1 ? 0 : (r < 3 ? $urandom_range(0, 2097151)
                                            : $urandom_range(2048, 2048000)));
        write_reg(CFG_SLICES, $urandom_range(0, 9) < 8 ? $urandom_range(1, 16)
                                                     : $urandom_range(0, 31));
        r = $urandom_range(0, 9);
        write_reg(CFG_START, r < 5 ? 0 : (r < 9 ? $urandom_range(0, 65536)
                                            : $urandom_range(0, 131071)));
        r = $urandom_range(0, 9);
        write_reg(CFG_LENGTH, r < 4 ? 65536 : (r < 9 ? $urandom_range(0, 65536)
                                               : $urandom_range(0, 131071)));
        r = $urandom_range(0, 9);
        write_reg(CFG_FRAMES, r < 1 ? $urandom_range(0, 1) : (r < 4 ? $urandom_range(2, 64)
                              : (r < 8 ? $urandom_range(65, 65536) : $urandom_range(0, 131071))));
        r = $urandom_range(0, 9);
        write_reg(CFG_RATE, r < 3 ? 65536 : (r < 8 ? $urandom_range(0, 131072)
                                             : $urandom_range(0, 524287)));
    endtask

    task automatic random_phase(int n);
        int sent, run, k;
        bit pconn, sconn, noisy;
        logic [16:0] spos;
        logic [22:0] freq;
        sent = 0;
        while (sent < n)
        begin
            if ($urandom_range(0, 9) < 2)
            begin
                load_word($urandom, $urandom);
                sent++;
                continue;
            end
            run = $urandom_range(1, 30);
            pconn = $urandom_range(0, 3) != 0;
            sconn = $urandom_range(0, 3) != 0;
            noisy = $urandom_range(0, 9) == 0;
            spos = $urandom_range(0, 4) == 0 ? 17'd65536 : 17'($urandom_range(0, 65536));
            freq = $urandom_range(0, 4) == 0 ? 23'($urandom_range(0, 8388607))
                                             : 23'($urandom_range(2048, 600000));
            tick(0, sconn, spos, pconn, freq);
            for (k = 0; k < run; k++)
                tick(noisy ? $urandom_range(0, 1) : 1'b1, sconn,
                     noisy ? $urandom_range(0, 131071) : spos, pconn, freq);
            sent += run + 1;
        end
    endtask

    initial
    begin
        int a;
        model.reset();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        no_idle = 1;
        for (a = 0; a < 65536; a++)
            load_word(a, a == 1 ? 16'h8000 : (a == 2 ? 16'h7FFF : 16'($urandom)));
        no_idle = 0;

        tick(1, 0, 0, 0, 0);
        drain();
        write_reg(CFG_FRAMES, 1);
        tick(0, 0, 0, 0, 0);
        tick(1, 0, 0, 0, 0);
        drain();
        write_reg(CFG_FRAMES, 65536);
        write_reg(CFG_LEVEL, 65536);
        write_reg(CFG_LOOP, 1);
        write_reg(CFG_SLICES, 16);
        write_reg(CFG_ROOT, 2048);
        write_reg(CFG_RATE, 262144);
        tick(0, 1, 65536, 1, 8388607);
        tick(1, 1, 65536, 1, 8388607);
        tick(1, 1, 65536, 1, 6144000);
        tick(1, 0, 0, 0, 0);
        load_word(0, 16'h8000);
        load_word(65535, 16'h7FFF);
        drain();
        write_reg(CFG_ROOT, 0);
        write_reg(CFG_RATE, 1);
        tick(0, 0, 0, 1, 1000);
        tick(1, 0, 0, 1, 1000);
        tick(1, 0, 0, 1, 1000);
        tick(1, 0, 0, 1, 0);
        drain();
        write_reg(CFG_LENGTH, 0);
        tick(0, 1, 0, 0, 0);
        tick(1, 1, 0, 0, 0);
        drain();
        write_reg(CFG_START, 65536);
        write_reg(CFG_LENGTH, 65536);
        tick(0, 0, 0, 0, 0);
        tick(1, 0, 0, 0, 0);
        drain();
        write_reg(CFG_START, 0);
        write_reg(CFG_LEVEL, 0);
        write_reg(CFG_RATE, 0);
        write_reg(CFG_LOOP, 0);
        write_reg(CFG_SLICES, 1);
        tick(0, 0, 0, 0, 0);
        tick(1, 0, 0, 0, 0);
        tick(1, 0, 0, 0, 0);
        drain();
        write_reg(CFG_LEVEL, 131071);
        write_reg(CFG_RATE, 524287);
        write_reg(CFG_SLICES, 31);
        tick(0, 1, 131071, 0, 0);
        tick(1, 1, 131071, 0, 0);
        tick(1, 1, 131071, 0, 0);
        drain();

        for (a = 0; a < 8; a++)
        begin
            random_setting();
            random_phase(105);
            drain();
        end

        if (model.errors == 0 && model.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
